// ===== sv/ncc_pkg.sv =====
package ncc_pkg;

  // Fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int SCORE_W   = 16;
  localparam int FRAC_BITS = 15;

  // Root search walks one score bit per step, top bit first
  localparam int                  STEP_W   = $clog2(SCORE_W);
  localparam logic [STEP_W-1:0]   STEP_TOP = STEP_W'(SCORE_W - 1);

  localparam logic [SCORE_W-1:0]  SCORE_MIN = {1'b1, {(SCORE_W - 1){1'b0}}};
  localparam logic [SCORE_W-1:0]  SCORE_MAX = {1'b0, {(SCORE_W - 1){1'b1}}};

  // Accumulators never grow beyond this width
  localparam int ACC_CAP = 64;

  // Finished windows waiting between front and back
  localparam int JOB_DEPTH = 2;

  typedef struct packed {
    logic empty;
    logic full;
    logic afull;
  } qstat_t;

endpackage

// ===== sv/normalized_cross_correlation.sv =====
// After the last pair of a window, the back multiplies one shift-add bit per cycle,
// then tries each score bit of the square-root search in ST_SRCH_A and ST_SRCH_B.
// Throughput: one sample pair per cycle; the front stalls when two finished windows
// already wait for the back, or one waits while another window end is on its way in.
// Reset (rst_ni low, asynchronous) clears the running sums, the queue and the valid flag.
module normalized_cross_correlation
  import ncc_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_PAIRS_LOG2 = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] ref_sample_i,
  input  logic signed [SAMPLE_W-1:0] cur_sample_i,
  input  logic                       last_i,
  input  logic                       pop,
  output logic                       empty,
  output logic signed [SCORE_W-1:0]  score_o,
  output logic                       degenerate_o
);

  localparam int CrossRaw   = 2 * SAMPLE_BITS + MAX_PAIRS_LOG2;
  localparam int EnergyRaw  = 2 * SAMPLE_BITS - 1 + MAX_PAIRS_LOG2;
  localparam int CrossBits  = (CrossRaw > ACC_CAP) ? ACC_CAP : CrossRaw;
  localparam int EnergyBits = (EnergyRaw > ACC_CAP) ? ACC_CAP : EnergyRaw;
  localparam int JobW       = CrossBits + 2 * EnergyBits;

  qstat_t                q_stat;
  logic                  job_push;
  logic [CrossBits-1:0]  f_cross;
  logic [EnergyBits-1:0] f_ref;
  logic [EnergyBits-1:0] f_cur;
  logic [JobW-1:0]       q_wdata;
  logic [JobW-1:0]       q_rdata;
  logic                  job_pop;

  ncc_front #(
    .SampleBits (SAMPLE_BITS),
    .CrossBits  (CrossBits),
    .EnergyBits (EnergyBits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .ref_sample_i (ref_sample_i),
    .cur_sample_i (cur_sample_i),
    .last_i       (last_i),
    .q_stat_i     (q_stat),
    .job_push_o   (job_push),
    .job_cross_o  (f_cross),
    .job_ref_o    (f_ref),
    .job_cur_o    (f_cur)
  );

  assign q_wdata = {f_cross, f_ref, f_cur};

  ncc_queue #(
    .Width (JobW),
    .Depth (JOB_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (q_wdata),
    .pop_i  (job_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  ncc_back #(
    .CrossBits  (CrossBits),
    .EnergyBits (EnergyBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_vld_i    (~q_stat.empty),
    .job_cross_i  (q_rdata[JobW-1 -: CrossBits]),
    .job_ref_i    (q_rdata[2*EnergyBits-1 -: EnergyBits]),
    .job_cur_i    (q_rdata[EnergyBits-1:0]),
    .job_pop_o    (job_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .score_o      (score_o),
    .degenerate_o (degenerate_o)
  );

endmodule

// ===== sv/ncc_front.sv =====
module ncc_front
  import ncc_pkg::*;
#(
  parameter int SampleBits = 16,
  parameter int CrossBits  = 52,
  parameter int EnergyBits = 51
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic signed [SAMPLE_W-1:0]   ref_sample_i,
  input  logic signed [SAMPLE_W-1:0]   cur_sample_i,
  input  logic                         last_i,
  input  qstat_t                       q_stat_i,
  output logic                         job_push_o,
  output logic [CrossBits-1:0]         job_cross_o,
  output logic [EnergyBits-1:0]        job_ref_o,
  output logic [EnergyBits-1:0]        job_cur_o
);

  localparam int RawW  = (SampleBits > SAMPLE_W) ? SampleBits : SAMPLE_W;
  localparam int ProdW = 2 * SampleBits;

  logic                         accept;
  logic [RawW-1:0]              ref_raw;
  logic [RawW-1:0]              cur_raw;
  logic signed [SampleBits-1:0] ref_s;
  logic signed [SampleBits-1:0] cur_s;
  logic signed [ProdW-1:0]      rc_prod;
  logic signed [ProdW-1:0]      rr_prod;
  logic signed [ProdW-1:0]      cc_prod;

  logic                         vld_q;
  logic                         last_q;
  logic signed [ProdW-1:0]      rc_q;
  logic [ProdW-1:0]             rr_q;
  logic [ProdW-1:0]             cc_q;

  logic [CrossBits-1:0]         cross_q;
  logic [EnergyBits-1:0]        ref_en_q;
  logic [EnergyBits-1:0]        cur_en_q;
  logic [CrossBits-1:0]         cross_d;
  logic [EnergyBits-1:0]        ref_en_d;
  logic [EnergyBits-1:0]        cur_en_d;

  // Hold off new items while a window end could find the queue full
  assign full_o = q_stat_i.full | (q_stat_i.afull & vld_q & last_q);
  assign accept = push_i & ~full_o;

  // Take the low sample bits as two's complement
  assign ref_raw = RawW'($unsigned(ref_sample_i));
  assign cur_raw = RawW'($unsigned(cur_sample_i));
  assign ref_s   = $signed(ref_raw[SampleBits-1:0]);
  assign cur_s   = $signed(cur_raw[SampleBits-1:0]);

  assign rc_prod = ref_s * cur_s;
  assign rr_prod = ref_s * ref_s;
  assign cc_prod = cur_s * cur_s;

  // Register products
  always_ff @(posedge clk_i) begin
    rc_q <= rc_prod;
    rr_q <= $unsigned(rr_prod);
    cc_q <= $unsigned(cc_prod);
  end

  // Add products to the running sums, wrapping at the sum widths
  assign cross_d  = cross_q + CrossBits'(rc_q);
  assign ref_en_d = ref_en_q + EnergyBits'(rr_q);
  assign cur_en_d = cur_en_q + EnergyBits'(cc_q);

  // Hand the finished sums to the queue on the window end
  assign job_push_o  = vld_q & last_q;
  assign job_cross_o = cross_d;
  assign job_ref_o   = ref_en_d;
  assign job_cur_o   = cur_en_d;

  // Advance product stage, accumulate, clear after a window end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      last_q   <= 1'b0;
      cross_q  <= '0;
      ref_en_q <= '0;
      cur_en_q <= '0;
    end else begin
      vld_q  <= accept;
      last_q <= accept & last_i;
      if (vld_q) begin
        if (last_q) begin
          cross_q  <= '0;
          ref_en_q <= '0;
          cur_en_q <= '0;
        end else begin
          cross_q  <= cross_d;
          ref_en_q <= ref_en_d;
          cur_en_q <= cur_en_d;
        end
      end
    end
  end

endmodule

// ===== sv/ncc_queue.sv =====
module ncc_queue
  import ncc_pkg::*;
#(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output qstat_t           stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push;
  logic             do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.afull = (cnt_q == CntW'(Depth - 1));

  assign do_push = push_i & ~stat_o.full;
  assign do_pop  = pop_i & ~stat_o.empty;
  assign data_o  = slot_q[rd_ptr_q];

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/ncc_back.sv =====
module ncc_back
  import ncc_pkg::*;
#(
  parameter int CrossBits  = 52,
  parameter int EnergyBits = 51
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_vld_i,
  input  logic [CrossBits-1:0]        job_cross_i,
  input  logic [EnergyBits-1:0]       job_ref_i,
  input  logic [EnergyBits-1:0]       job_cur_i,
  output logic                        job_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic signed [SCORE_W-1:0]   score_o,
  output logic                        degenerate_o
);

  localparam int PW     = 2 * EnergyBits;
  localparam int MW     = 2 * CrossBits;
  localparam int WW     = 2 * CrossBits + 2 * FRAC_BITS + 2;
  localparam int RShift = 2 * FRAC_BITS;
  localparam int CntW   = $clog2(CrossBits + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_SRCH_A = 3'd3;
  localparam logic [2:0] ST_SRCH_B = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [STEP_W-1:0]    k_q, k_d;
  logic                 out_vld_q, out_vld_d;

  logic                 neg_q;
  logic [PW-1:0]        mcand_p_q;
  logic [EnergyBits-1:0] mplier_p_q;
  logic [PW-1:0]        p_q;
  logic [MW-1:0]        mcand_m_q;
  logic [CrossBits-1:0] mplier_m_q;
  logic [MW-1:0]        m2_q;

  logic [WW-1:0]        a_q;
  logic [WW-1:0]        b_q;
  logic [WW-1:0]        t_q;
  logic [WW-1:0]        s_q;
  logic [WW-1:0]        ba_q;
  logic [SCORE_W-1:0]   q_q;

  logic [SCORE_W-1:0]   res_score_q;
  logic                 res_degen_q;
  logic [SCORE_W-1:0]   score_q;
  logic                 degen_q;

  logic [CrossBits-1:0] mag;
  logic                 degen;
  logic [WW-1:0]        bound;
  logic [WW-1:0]        cand;
  logic                 fit;
  logic [SCORE_W-1:0]   q_new;
  logic                 srch_done;
  logic [SCORE_W-1:0]   score_new;

  // Classify the job: magnitude of the cross sum and the zero-energy case
  assign mag   = job_cross_i[CrossBits-1] ? (~job_cross_i + CrossBits'(1)) : job_cross_i;
  assign degen = (job_ref_i == '0) | (job_cur_i == '0);

  // Trial of one score bit: (q + 2^k)^2 * P against cross^2 * 2^30
  assign bound     = WW'({m2_q, {RShift{1'b0}}});
  assign cand      = s_q + a_q;
  assign fit       = (cand <= bound);
  assign q_new     = fit ? (q_q | (SCORE_W'(1) << k_q)) : q_q;
  assign srch_done = (fit && (k_q == STEP_TOP)) || (k_q == '0);
  assign score_new = neg_q ? (~q_new + SCORE_W'(1)) :
                     (q_new[SCORE_W-1] ? SCORE_MAX : q_new);

  assign job_pop_o    = (state_q == ST_IDLE) & job_vld_i;
  assign empty_o      = ~out_vld_q;
  assign score_o      = $signed(score_q);
  assign degenerate_o = degen_q;

  // Sequence one job: load, multiply, search, deliver; a degenerate job goes straight to deliver
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    out_vld_d = out_vld_q & ~pop_i;
    case (state_q)
      ST_IDLE: begin
        if (job_vld_i) begin
          cnt_d   = CntW'(CrossBits);
          state_d = degen ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        k_d     = STEP_TOP;
        state_d = ST_SRCH_A;
      end
      ST_SRCH_A: begin
        state_d = ST_SRCH_B;
      end
      ST_SRCH_B: begin
        k_d     = k_q - 1'b1;
        state_d = srch_done ? ST_OUT : ST_SRCH_A;
      end
      ST_OUT: begin
        if (!out_vld_q) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (job_vld_i) begin
          neg_q       <= job_cross_i[CrossBits-1];
          mcand_p_q   <= PW'(job_ref_i);
          mplier_p_q  <= job_cur_i;
          p_q         <= '0;
          mcand_m_q   <= MW'(mag);
          mplier_m_q  <= mag;
          m2_q        <= '0;
          res_score_q <= SCORE_MIN;
          res_degen_q <= degen;
        end
      end
      ST_MUL: begin
        // Shift-add both products one multiplier bit a cycle
        if (mplier_p_q[0]) begin
          p_q <= p_q + mcand_p_q;
        end
        if (mplier_m_q[0]) begin
          m2_q <= m2_q + mcand_m_q;
        end
        mcand_p_q  <= mcand_p_q << 1;
        mplier_p_q <= mplier_p_q >> 1;
        mcand_m_q  <= mcand_m_q << 1;
        mplier_m_q <= mplier_m_q >> 1;
      end
      ST_PREP: begin
        a_q <= WW'({p_q, {RShift{1'b0}}});
        b_q <= '0;
        t_q <= '0;
        q_q <= '0;
      end
      ST_SRCH_A: begin
        s_q  <= t_q + b_q;
        ba_q <= (b_q >> 1) + a_q;
      end
      ST_SRCH_B: begin
        // Keep the bit if the square still fits, then move one bit down
        if (fit) begin
          t_q <= cand;
          b_q <= ba_q;
        end else begin
          b_q <= b_q >> 1;
        end
        a_q <= a_q >> 2;
        q_q <= q_new;
        if (srch_done) begin
          res_score_q <= score_new;
          res_degen_q <= 1'b0;
        end
      end
      ST_OUT: begin
        if (!out_vld_q) begin
          score_q <= res_score_q;
          degen_q <= res_degen_q;
        end
      end
      default: begin
        q_q <= q_q;
      end
    endcase
  end

endmodule
